[sv/dss_pkg.sv]
`default_nettype none
package dss_pkg;

   localparam logic [31:0] UNREACHED = 32'd4294967294;

   localparam logic [4:0]  DELTA_SHIFT_RESET = 5'd10;
   localparam logic [10:0] NODE_COUNT_RESET  = 11'd1024;

   typedef enum logic [1:0] {
      OP_WRITE_OFFSET = 2'd0,
      OP_WRITE_EDGE   = 2'd1,
      OP_RUN          = 2'd2,
      OP_READ         = 2'd3
   } op_type;

   typedef enum logic {
      ST_OK    = 1'b0,
      ST_RANGE = 1'b1
   } status_type;

   typedef enum logic {
      REG_DELTA_SHIFT = 1'b0,
      REG_NODE_COUNT  = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [31:0] path_len;
      logic        pending;
      logic        removed;
   } node_entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } eng_status_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_READ,
      TOP_RUN
   } top_state_type;

   typedef enum logic [3:0] {
      ENG_IDLE,
      ENG_CLEAR,
      ENG_SEED,
      ENG_SCAN_RD,
      ENG_SCAN_CHK,
      ENG_SWEEP_RD,
      ENG_SWEEP_CHK,
      ENG_ROW_HI,
      ENG_ROW_WAIT,
      ENG_EDGE_RD,
      ENG_EDGE_CHK,
      ENG_NODE_CHK,
      ENG_HEAVY_RD,
      ENG_HEAVY_LIST,
      ENG_HEAVY_NODE,
      ENG_DONE
   } eng_state_type;

endpackage
`default_nettype wire

[sv/dss_stream_if.sv]
`default_nettype none
interface dss_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [10:0] node;
   logic [12:0] first_edge;
   logic [11:0] edge_index;
   logic [9:0]  edge_dest;
   logic [31:0] edge_weight;

   modport source (output valid, op, node, first_edge, edge_index, edge_dest, edge_weight,
                   input ready);
   modport sink   (input valid, op, node, first_edge, edge_index, edge_dest, edge_weight,
                   output ready);
endinterface

interface dss_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] distance;
   logic        status;

   modport source (output valid, distance, status, input ready);
   modport sink   (input valid, distance, status, output ready);
endinterface
`default_nettype wire

[sv/dss_graph_store.sv]
`default_nettype none
module dss_graph_store #(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096,
   localparam int NA_W  = $clog2(MAX_NODES),
   localparam int RA_W  = $clog2(MAX_NODES + 1),
   localparam int EA_W  = $clog2(MAX_EDGES),
   localparam int OFF_W = $clog2(MAX_EDGES + 1)
) (
   input  wire logic             clock,
   input  wire logic             row_wr_en,
   input  wire logic [RA_W-1:0]  row_wr_addr,
   input  wire logic [OFF_W-1:0] row_wr_data,
   input  wire logic [RA_W-1:0]  row_rd_addr,
   output logic      [OFF_W-1:0] row_rd_data,
   input  wire logic             edge_wr_en,
   input  wire logic [EA_W-1:0]  edge_wr_addr,
   input  wire logic [NA_W-1:0]  edge_wr_dest,
   input  wire logic [31:0]      edge_wr_weight,
   input  wire logic [EA_W-1:0]  edge_rd_addr,
   output logic      [NA_W-1:0]  edge_rd_dest,
   output logic      [31:0]      edge_rd_weight
);

   logic [OFF_W-1:0] row_mem_ff  [MAX_NODES+1];
   logic [NA_W-1:0]  dest_mem_ff [MAX_EDGES];
   logic [31:0]      cost_mem_ff [MAX_EDGES];
   logic [OFF_W-1:0] row_rd_ff;
   logic [NA_W-1:0]  dest_rd_ff;
   logic [31:0]      cost_rd_ff;

   always_ff @(posedge clock) begin
      if (row_wr_en) begin
         row_mem_ff[row_wr_addr] <= row_wr_data;
      end
      row_rd_ff <= row_mem_ff[row_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (edge_wr_en) begin
         dest_mem_ff[edge_wr_addr] <= edge_wr_dest;
         cost_mem_ff[edge_wr_addr] <= edge_wr_weight;
      end
      dest_rd_ff <= dest_mem_ff[edge_rd_addr];
      cost_rd_ff <= cost_mem_ff[edge_rd_addr];
   end

   assign row_rd_data    = row_rd_ff;
   assign edge_rd_dest   = dest_rd_ff;
   assign edge_rd_weight = cost_rd_ff;

endmodule
`default_nettype wire

[sv/dss_node_store.sv]
`default_nettype none
module dss_node_store #(
   parameter int MAX_NODES = 1024,
   localparam int NA_W = $clog2(MAX_NODES)
) (
   input  wire logic                    clock,
   input  wire logic [NA_W-1:0]         rd_addr,
   output dss_pkg::node_entry_type      rd_data,
   input  wire logic                    wr_en,
   input  wire logic [NA_W-1:0]         wr_addr,
   input  wire dss_pkg::node_entry_type wr_data
);

   dss_pkg::node_entry_type mem_ff [MAX_NODES];
   dss_pkg::node_entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire

[sv/dss_engine.sv]
`default_nettype none
module dss_engine #(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096,
   localparam int NA_W  = $clog2(MAX_NODES),
   localparam int CNT_W = $clog2(MAX_NODES + 1),
   localparam int RA_W  = $clog2(MAX_NODES + 1),
   localparam int EA_W  = $clog2(MAX_EDGES),
   localparam int OFF_W = $clog2(MAX_EDGES + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [NA_W-1:0]         src,
   input  wire logic [CNT_W-1:0]        n_eff,
   input  wire logic [4:0]              delta_shift,
   output dss_pkg::eng_status_type      status,
   output logic      [NA_W-1:0]         node_rd_addr,
   input  wire dss_pkg::node_entry_type node_rd_data,
   output logic                         node_wr_en,
   output logic      [NA_W-1:0]         node_wr_addr,
   output dss_pkg::node_entry_type      node_wr_data,
   output logic      [RA_W-1:0]         row_rd_addr,
   input  wire logic [OFF_W-1:0]        row_rd_data,
   output logic      [EA_W-1:0]         edge_rd_addr,
   input  wire logic [NA_W-1:0]         edge_rd_dest,
   input  wire logic [31:0]             edge_rd_weight
);

   dss_pkg::eng_state_type state_ff, state_in;
   logic [NA_W-1:0]  v_ff, v_in, u_ff, u_in, t_ff, t_in;
   logic [31:0]      du_ff, du_in, best_ff, best_in, w_ff, w_in;
   logic             found_ff, found_in, progress_ff, progress_in, heavy_ff, heavy_in;
   logic [CNT_W-1:0] count_ff, count_in, idx_ff, idx_in;
   logic [OFF_W-1:0] e_ff, e_in, hi_ff, hi_in, lo_ff, lo_in;

   logic [NA_W-1:0]  list_mem_ff [MAX_NODES];
   logic [NA_W-1:0]  list_rd_ff;
   logic             list_wr_en;

   logic             last_v, clear_last, found_now, is_heavy;
   logic [31:0]      bucket, best_now;
   logic [32:0]      sum_raw;
   logic [31:0]      sum_sat;
   logic [OFF_W-1:0] hi_clip, lo_clip;

   always_ff @(posedge clock) begin
      if (list_wr_en) begin
         list_mem_ff[count_ff[NA_W-1:0]] <= v_ff;
      end
      list_rd_ff <= list_mem_ff[idx_ff[NA_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dss_pkg::ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
      v_ff        <= v_in;
      u_ff        <= u_in;
      t_ff        <= t_in;
      du_ff       <= du_in;
      best_ff     <= best_in;
      w_ff        <= w_in;
      found_ff    <= found_in;
      progress_ff <= progress_in;
      heavy_ff    <= heavy_in;
      count_ff    <= count_in;
      idx_ff      <= idx_in;
      e_ff        <= e_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
   end

   assign last_v     = (CNT_W'(v_ff) + CNT_W'(1)) == n_eff;
   assign clear_last = v_ff == NA_W'(MAX_NODES - 1);
   assign bucket     = node_rd_data.path_len >> delta_shift;
   assign found_now  = found_ff | node_rd_data.pending;
   assign best_now   = (node_rd_data.pending && (!found_ff || bucket < best_ff)) ?
                       bucket : best_ff;
   assign is_heavy   = {1'b0, edge_rd_weight} > (33'd1 << delta_shift);
   assign sum_raw    = {1'b0, du_ff} + {1'b0, w_ff};
   assign sum_sat    = (sum_raw > {1'b0, dss_pkg::UNREACHED}) ? dss_pkg::UNREACHED :
                       sum_raw[31:0];
   assign hi_clip    = (32'(row_rd_data) > 32'(MAX_EDGES)) ? OFF_W'(MAX_EDGES) : row_rd_data;
   assign lo_clip    = (lo_ff > hi_clip) ? hi_clip : lo_ff;

   always_comb begin
      state_in     = state_ff;
      v_in         = v_ff;
      u_in         = u_ff;
      t_in         = t_ff;
      du_in        = du_ff;
      best_in      = best_ff;
      w_in         = w_ff;
      found_in     = found_ff;
      progress_in  = progress_ff;
      heavy_in     = heavy_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      e_in         = e_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      list_wr_en   = 1'b0;
      node_rd_addr = v_ff;
      node_wr_en   = 1'b0;
      node_wr_addr = v_ff;
      node_wr_data = '{path_len: dss_pkg::UNREACHED, pending: 1'b0, removed: 1'b0};
      row_rd_addr  = RA_W'(u_ff);
      edge_rd_addr = e_ff[EA_W-1:0];
      status       = '{busy: state_ff != dss_pkg::ENG_IDLE, done: 1'b0};

      unique case (state_ff)
         dss_pkg::ENG_IDLE: begin
            if (start) begin
               // hold the source until the clear pass is over
               v_in     = '0;
               u_in     = src;
               state_in = dss_pkg::ENG_CLEAR;
            end
         end
         dss_pkg::ENG_CLEAR: begin
            node_wr_en = 1'b1;
            v_in       = v_ff + NA_W'(1);
            if (clear_last) begin
               state_in = dss_pkg::ENG_SEED;
            end
         end
         dss_pkg::ENG_SEED: begin
            node_wr_en   = 1'b1;
            node_wr_addr = u_ff;
            node_wr_data = '{path_len: 32'd0, pending: 1'b1, removed: 1'b0};
            v_in         = '0;
            found_in     = 1'b0;
            state_in     = dss_pkg::ENG_SCAN_RD;
         end
         dss_pkg::ENG_SCAN_RD: begin
            state_in = dss_pkg::ENG_SCAN_CHK;
         end
         dss_pkg::ENG_SCAN_CHK: begin
            found_in = found_now;
            best_in  = best_now;
            if (last_v) begin
               v_in = '0;
               if (found_now) begin
                  progress_in = 1'b0;
                  count_in    = '0;
                  state_in    = dss_pkg::ENG_SWEEP_RD;
               end else begin
                  state_in = dss_pkg::ENG_DONE;
               end
            end else begin
               v_in     = v_ff + NA_W'(1);
               state_in = dss_pkg::ENG_SCAN_RD;
            end
         end
         dss_pkg::ENG_SWEEP_RD: begin
            state_in = dss_pkg::ENG_SWEEP_CHK;
         end
         dss_pkg::ENG_SWEEP_CHK: begin
            if (node_rd_data.pending && bucket == best_ff) begin
               node_wr_en   = 1'b1;
               node_wr_data = '{path_len: node_rd_data.path_len, pending: 1'b0,
                                removed: 1'b1};
               if (!node_rd_data.removed) begin
                  list_wr_en = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
               end
               progress_in = 1'b1;
               u_in        = v_ff;
               du_in       = node_rd_data.path_len;
               heavy_in    = 1'b0;
               row_rd_addr = RA_W'(v_ff);
               state_in    = dss_pkg::ENG_ROW_HI;
            end else if (last_v) begin
               v_in = '0;
               if (progress_ff) begin
                  progress_in = 1'b0;
                  state_in    = dss_pkg::ENG_SWEEP_RD;
               end else if (count_ff == '0) begin
                  found_in = 1'b0;
                  state_in = dss_pkg::ENG_SCAN_RD;
               end else begin
                  idx_in   = '0;
                  state_in = dss_pkg::ENG_HEAVY_RD;
               end
            end else begin
               v_in     = v_ff + NA_W'(1);
               state_in = dss_pkg::ENG_SWEEP_RD;
            end
         end
         dss_pkg::ENG_ROW_HI: begin
            // low offset arrives now; ask for the next row's offset
            lo_in       = row_rd_data;
            row_rd_addr = RA_W'(u_ff) + RA_W'(1);
            state_in    = dss_pkg::ENG_ROW_WAIT;
         end
         dss_pkg::ENG_ROW_WAIT: begin
            hi_in    = hi_clip;
            e_in     = lo_clip;
            state_in = dss_pkg::ENG_EDGE_RD;
         end
         dss_pkg::ENG_EDGE_RD: begin
            if (e_ff < hi_ff) begin
               state_in = dss_pkg::ENG_EDGE_CHK;
            end else if (heavy_ff) begin
               idx_in = idx_ff + CNT_W'(1);
               if (idx_ff + CNT_W'(1) == count_ff) begin
                  v_in     = '0;
                  found_in = 1'b0;
                  state_in = dss_pkg::ENG_SCAN_RD;
               end else begin
                  state_in = dss_pkg::ENG_HEAVY_RD;
               end
            end else if (last_v) begin
               // progress is set: this sweep removed the node just done
               v_in        = '0;
               progress_in = 1'b0;
               state_in    = dss_pkg::ENG_SWEEP_RD;
            end else begin
               v_in     = v_ff + NA_W'(1);
               state_in = dss_pkg::ENG_SWEEP_RD;
            end
         end
         dss_pkg::ENG_EDGE_CHK: begin
            w_in         = edge_rd_weight;
            t_in         = edge_rd_dest;
            node_rd_addr = edge_rd_dest;
            if (is_heavy != heavy_ff || CNT_W'(edge_rd_dest) >= n_eff) begin
               e_in     = e_ff + OFF_W'(1);
               state_in = dss_pkg::ENG_EDGE_RD;
            end else begin
               state_in = dss_pkg::ENG_NODE_CHK;
            end
         end
         dss_pkg::ENG_NODE_CHK: begin
            if (sum_sat < node_rd_data.path_len) begin
               node_wr_en   = 1'b1;
               node_wr_addr = t_ff;
               node_wr_data = '{path_len: sum_sat, pending: 1'b1,
                                removed: node_rd_data.removed};
            end
            e_in     = e_ff + OFF_W'(1);
            state_in = dss_pkg::ENG_EDGE_RD;
         end
         dss_pkg::ENG_HEAVY_RD: begin
            state_in = dss_pkg::ENG_HEAVY_LIST;
         end
         dss_pkg::ENG_HEAVY_LIST: begin
            u_in         = list_rd_ff;
            node_rd_addr = list_rd_ff;
            state_in     = dss_pkg::ENG_HEAVY_NODE;
         end
         dss_pkg::ENG_HEAVY_NODE: begin
            du_in       = node_rd_data.path_len;
            heavy_in    = 1'b1;
            row_rd_addr = RA_W'(u_ff);
            state_in    = dss_pkg::ENG_ROW_HI;
         end
         dss_pkg::ENG_DONE: begin
            status.done = 1'b1;
            state_in    = dss_pkg::ENG_IDLE;
         end
         default: begin
            state_in = dss_pkg::ENG_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[sv/delta_stepping_sssp.sv]
// Offset and edge writes: result registered at the transfer, one item per cycle while the
// result register is free or draining. Distance reads: node memory read at the transfer,
// result loaded in TOP_READ, no new request taken meanwhile; a read before the first run has
// its result registered at the transfer. Runs: clear and seed, then per bucket a scan and
// sweeps over the nodes, row reads per swept node, a heavy pass and a check per edge.
// Reset clears control and registers; distance reads before the first run return unreachable.
`default_nettype none
module delta_stepping_sssp #(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   dss_req_if.sink          req_ch,
   dss_rsp_if.source        rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int NA_W  = $clog2(MAX_NODES);
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int RA_W  = $clog2(MAX_NODES + 1);
   localparam int EA_W  = $clog2(MAX_EDGES);
   localparam int OFF_W = $clog2(MAX_EDGES + 1);

   dss_pkg::top_state_type state_ff, state_in;
   logic [4:0]   delta_shift_ff;
   logic [10:0]  node_count_ff;
   logic         ran_ff, ran_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  rsp_dist_ff, rsp_dist_in;
   logic         rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0] n_eff;
   logic             take, node_bad, csr_write;
   logic             row_wr_en, edge_wr_en, eng_start;
   logic [NA_W-1:0]  host_addr;

   dss_pkg::eng_status_type eng_status;
   dss_pkg::node_entry_type node_rd_data, node_wr_data;
   logic [NA_W-1:0]  eng_rd_addr, node_rd_addr, node_wr_addr;
   logic             node_wr_en;
   logic [RA_W-1:0]  row_rd_addr;
   logic [OFF_W-1:0] row_rd_data;
   logic [EA_W-1:0]  edge_rd_addr;
   logic [NA_W-1:0]  edge_rd_dest;
   logic [31:0]      edge_rd_weight;

   // ---------------------------------------------------------------- registers
   // The register index is the word address; the low address bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_shift_ff <= dss_pkg::DELTA_SHIFT_RESET;
         node_count_ff  <= dss_pkg::NODE_COUNT_RESET;
      end else if (csr_write) begin
         unique case (dss_pkg::reg_index_type'(csr_paddr[2]))
            dss_pkg::REG_DELTA_SHIFT: delta_shift_ff <= csr_pwdata[4:0];
            dss_pkg::REG_NODE_COUNT:  node_count_ff  <= csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (dss_pkg::reg_index_type'(csr_paddr[2]))
         dss_pkg::REG_DELTA_SHIFT: csr_prdata = {27'd0, delta_shift_ff};
         dss_pkg::REG_NODE_COUNT:  csr_prdata = {21'd0, node_count_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // Node count beyond the node memory counts as the full memory.
   assign n_eff = (32'(node_count_ff) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES) :
                  CNT_W'(node_count_ff);

   // ---------------------------------------------------------------- request side
   // Take a request only when idle and the result register is free or draining.
   assign req_ch.ready = (state_ff == dss_pkg::TOP_IDLE) & (~rsp_valid_ff | rsp_ch.ready);
   assign take         = req_ch.valid & req_ch.ready;
   assign node_bad     = 32'(req_ch.node) >= 32'(n_eff);
   assign host_addr    = req_ch.node[NA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dss_pkg::TOP_IDLE;
         ran_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ran_ff       <= ran_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_dist_ff   <= rsp_dist_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      logic load;
      load          = 1'b0;
      state_in      = state_ff;
      ran_in        = ran_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_status_in = rsp_status_ff;
      row_wr_en     = 1'b0;
      edge_wr_en    = 1'b0;
      eng_start     = 1'b0;

      unique case (state_ff)
         dss_pkg::TOP_IDLE: begin
            if (take) begin
               unique case (dss_pkg::op_type'(req_ch.op))
                  dss_pkg::OP_WRITE_OFFSET: begin
                     load        = 1'b1;
                     rsp_dist_in = '0;
                     if (32'(req_ch.node) > 32'(MAX_NODES) ||
                         32'(req_ch.first_edge) > 32'(MAX_EDGES)) begin
                        rsp_status_in = dss_pkg::ST_RANGE;
                     end else begin
                        rsp_status_in = dss_pkg::ST_OK;
                        row_wr_en     = 1'b1;
                     end
                  end
                  dss_pkg::OP_WRITE_EDGE: begin
                     load        = 1'b1;
                     rsp_dist_in = '0;
                     if (32'(req_ch.edge_index) >= 32'(MAX_EDGES) ||
                         32'(req_ch.edge_dest) >= 32'(MAX_NODES)) begin
                        rsp_status_in = dss_pkg::ST_RANGE;
                     end else begin
                        rsp_status_in = dss_pkg::ST_OK;
                        edge_wr_en    = 1'b1;
                     end
                  end
                  dss_pkg::OP_RUN: begin
                     if (node_bad) begin
                        load          = 1'b1;
                        rsp_dist_in   = '0;
                        rsp_status_in = dss_pkg::ST_RANGE;
                     end else begin
                        eng_start = 1'b1;
                        ran_in    = 1'b1;
                        state_in  = dss_pkg::TOP_RUN;
                     end
                  end
                  dss_pkg::OP_READ: begin
                     if (node_bad) begin
                        load          = 1'b1;
                        rsp_dist_in   = '0;
                        rsp_status_in = dss_pkg::ST_RANGE;
                     end else if (!ran_ff) begin
                        // node memory is still uncleared: every node is unreachable
                        load          = 1'b1;
                        rsp_dist_in   = dss_pkg::UNREACHED;
                        rsp_status_in = dss_pkg::ST_OK;
                     end else begin
                        state_in = dss_pkg::TOP_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         dss_pkg::TOP_READ: begin
            // node read issued at the transfer; data is here now
            load          = 1'b1;
            rsp_dist_in   = node_rd_data.path_len;
            rsp_status_in = dss_pkg::ST_OK;
            state_in      = dss_pkg::TOP_IDLE;
         end
         dss_pkg::TOP_RUN: begin
            if (eng_status.done) begin
               load          = 1'b1;
               rsp_dist_in   = '0;
               rsp_status_in = dss_pkg::ST_OK;
               state_in      = dss_pkg::TOP_IDLE;
            end
         end
         default: begin
            state_in = dss_pkg::TOP_IDLE;
         end
      endcase

      rsp_valid_in = load | (rsp_valid_ff & ~rsp_ch.ready);
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.distance = rsp_dist_ff;
   assign rsp_ch.status   = rsp_status_ff;

   // ---------------------------------------------------------------- storage
   // The engine owns the node memory read port while a run is in flight.
   assign node_rd_addr = eng_status.busy ? eng_rd_addr : host_addr;

   dss_graph_store #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES)
   ) u_graph (
      .clock          (clock),
      .row_wr_en      (row_wr_en),
      .row_wr_addr    (req_ch.node[RA_W-1:0]),
      .row_wr_data    (OFF_W'(req_ch.first_edge)),
      .row_rd_addr    (row_rd_addr),
      .row_rd_data    (row_rd_data),
      .edge_wr_en     (edge_wr_en),
      .edge_wr_addr   (req_ch.edge_index[EA_W-1:0]),
      .edge_wr_dest   (NA_W'(req_ch.edge_dest)),
      .edge_wr_weight (req_ch.edge_weight),
      .edge_rd_addr   (edge_rd_addr),
      .edge_rd_dest   (edge_rd_dest),
      .edge_rd_weight (edge_rd_weight)
   );

   dss_node_store #(
      .MAX_NODES (MAX_NODES)
   ) u_nodes (
      .clock   (clock),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd_data),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_data)
   );

   // ---------------------------------------------------------------- run engine
   // Clear, seed, then per bucket: minimum scan, light sweeps until quiet,
   // heavy pass over the nodes removed from the bucket.
   dss_engine #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .start          (eng_start),
      .src            (host_addr),
      .n_eff          (n_eff),
      .delta_shift    (delta_shift_ff),
      .status         (eng_status),
      .node_rd_addr   (eng_rd_addr),
      .node_rd_data   (node_rd_data),
      .node_wr_en     (node_wr_en),
      .node_wr_addr   (node_wr_addr),
      .node_wr_data   (node_wr_data),
      .row_rd_addr    (row_rd_addr),
      .row_rd_data    (row_rd_data),
      .edge_rd_addr   (edge_rd_addr),
      .edge_rd_dest   (edge_rd_dest),
      .edge_rd_weight (edge_rd_weight)
   );

endmodule
`default_nettype wire

[tb/testbench.sv]
`default_nettype none
module testbench;

   localparam int NODES_MAX  = 1024;
   localparam int EDGES_MAX  = 4096;
   localparam int CYCLE_CAP  = 3000000;
   localparam int ITEM_GOAL  = 1450;
   localparam int HOLD_AT    = 400;
   localparam int HOLD_LEN   = 300;

   typedef struct {
      dss_pkg::op_type op;
      logic [10:0]     node;
      logic [12:0]     first_edge;
      logic [11:0]     edge_index;
      logic [9:0]      edge_dest;
      logic [31:0]     edge_weight;
   } req_item_type;

   typedef struct {
      logic [31:0]         distance;
      dss_pkg::status_type status;
   } rsp_item_type;

   logic clock;
   logic reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dss_req_if req_bus ();
   dss_rsp_if rsp_bus ();

   delta_stepping_sssp dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predicted block state: graph stores, distances, flags and registers.
   logic [12:0] row_off   [0:NODES_MAX];
   logic [9:0]  edge_to   [0:EDGES_MAX-1];
   logic [31:0] edge_wt   [0:EDGES_MAX-1];
   logic [31:0] dist_of   [0:NODES_MAX-1];
   bit          queued    [0:NODES_MAX-1];
   bit          settled   [0:NODES_MAX-1];
   int          settled_q [0:NODES_MAX-1];
   logic [4:0]  bucket_shift;
   logic [10:0] node_limit;

   req_item_type stim_q[$];
   rsp_item_type expected_rsp[$];
   req_item_type cur_req;
   int          planned;
   int          transfers_in;
   int          mismatches;
   int          cycles;
   int          send_gap;
   int          recv_stall;
   int          hold_left;
   bit          hold_done;
   bit          quiet;

   // Clock; the single reset at start of run is driven by the main initial block.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int live_nodes();
      return (node_limit > NODES_MAX) ? NODES_MAX : int'(node_limit);
   endfunction

   // Relax light or heavy out-edges of node u; path sums saturate at UNREACHED.
   function automatic void relax_out_edges(int u, bit heavy, int n);
      longint unsigned delta;
      longint unsigned sum;
      int lo;
      int hi;
      int t;
      bit is_heavy;
      logic [31:0] du;
      delta = 64'd1 << bucket_shift;
      lo = row_off[u];
      hi = row_off[u+1];
      du = dist_of[u];
      if (hi > EDGES_MAX) hi = EDGES_MAX;
      if (lo > hi) lo = hi;
      for (int e = lo; e < hi; e++) begin
         t = edge_to[e];
         is_heavy = longint'(edge_wt[e]) > delta;
         if (is_heavy != heavy || t >= n) continue;
         sum = longint'(du) + longint'(edge_wt[e]);
         if (sum > longint'(dss_pkg::UNREACHED)) sum = dss_pkg::UNREACHED;
         if (sum < dist_of[t]) begin
            dist_of[t] = sum[31:0];
            queued[t] = 1'b1;
         end
      end
   endfunction

   function automatic void shortest_path_run(int src, int n);
      bit found;
      bit progress;
      logic [31:0] best;
      int count;
      for (int v = 0; v < NODES_MAX; v++) begin
         dist_of[v] = dss_pkg::UNREACHED;
         queued[v] = 1'b0;
         settled[v] = 1'b0;
      end
      dist_of[src] = 0;
      queued[src] = 1'b1;
      forever begin
         found = 1'b0;
         best = 0;
         count = 0;
         for (int v = 0; v < n; v++)
            if (queued[v]) begin
               if (!found || (dist_of[v] >> bucket_shift) < best)
                  best = dist_of[v] >> bucket_shift;
               found = 1'b1;
            end
         if (!found) break;
         // Sweep the current bucket until no node lands in it again.
         do begin
            progress = 1'b0;
            for (int v = 0; v < n; v++)
               if (queued[v] && (dist_of[v] >> bucket_shift) == best) begin
                  queued[v] = 1'b0;
                  progress = 1'b1;
                  if (!settled[v]) begin
                     settled[v] = 1'b1;
                     settled_q[count] = v;
                     count++;
                  end
                  relax_out_edges(v, 1'b0, n);
               end
         end while (progress);
         for (int i = 0; i < count; i++) relax_out_edges(settled_q[i], 1'b1, n);
      end
   endfunction

   function automatic void apply_request(req_item_type it);
      rsp_item_type r;
      int n;
      n = live_nodes();
      r.distance = 0;
      r.status = dss_pkg::ST_OK;
      case (it.op)
         dss_pkg::OP_WRITE_OFFSET: begin
            if (it.node > NODES_MAX || it.first_edge > EDGES_MAX) r.status = dss_pkg::ST_RANGE;
            else row_off[it.node] = it.first_edge;
         end
         dss_pkg::OP_WRITE_EDGE: begin
            edge_to[it.edge_index] = it.edge_dest;
            edge_wt[it.edge_index] = it.edge_weight;
         end
         dss_pkg::OP_RUN: begin
            if (it.node >= n) r.status = dss_pkg::ST_RANGE;
            else shortest_path_run(it.node, n);
         end
         default: begin
            if (it.node >= n) r.status = dss_pkg::ST_RANGE;
            else r.distance = dist_of[it.node];
         end
      endcase
      expected_rsp.insert(expected_rsp.size(), r);
   endfunction

   // Queue an item; push_noop below fills the edge fields with random bits.
   function automatic void push_req(dss_pkg::op_type op, int node, int first_edge,
                                    int edge_index, int edge_dest, logic [31:0] w);
      req_item_type it;
      it.op = op;
      it.node = node;
      it.first_edge = first_edge;
      it.edge_index = edge_index;
      it.edge_dest = edge_dest;
      it.edge_weight = w;
      stim_q.insert(stim_q.size(), it);
      planned++;
   endfunction

   function automatic void push_noop(dss_pkg::op_type op, int node, int first_edge);
      push_req(op, node, first_edge, $urandom_range(0, 4095), $urandom_range(0, 1023),
               $urandom);
   endfunction

   function automatic logic [31:0] pick_weight(int shift);
      logic [31:0] delta;
      delta = 32'd1 << shift;
      case ($urandom_range(0, 6))
         0: return 32'd0;
         1: return $urandom_range(0, delta);
         2: return delta;
         3: return delta + 32'd1;
         4: return $urandom;
         5: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'hFFFF_FFFE;
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   // Driver: offer queued items, with random gaps outside the final stretch.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
         transfers_in = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_request(cur_req);
            transfers_in++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (stim_q.size() > 0) begin
               cur_req = stim_q[0];
               stim_q.delete(0);
               req_bus.op <= cur_req.op;
               req_bus.node <= cur_req.node;
               req_bus.first_edge <= cur_req.first_edge;
               req_bus.edge_index <= cur_req.edge_index;
               req_bus.edge_dest <= cur_req.edge_dest;
               req_bus.edge_weight <= cur_req.edge_weight;
               req_bus.valid <= 1'b1;
               if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, once, so the block backs up and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && transfers_in >= HOLD_AT) begin
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: compare each result transfer against the oldest prediction.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: distance %0d status %0d",
                           rsp_bus.distance, rsp_bus.status);
            end else begin
               want = expected_rsp[0];
               expected_rsp.delete(0);
               if (rsp_bus.distance !== want.distance || rsp_bus.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected distance %0d status %0d, got %0d status %0d",
                              want.distance, want.status, rsp_bus.distance, rsp_bus.status);
               end
            end
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_stall = $urandom_range(0, 7);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("FAIL delta_stepping_sssp");
         $finish;
      end
   end

   // Wait until every planned item has transferred and its result came back, then settle.
   task automatic wait_idle();
      while (transfers_in != planned || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(dss_pkg::reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(idx) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == dss_pkg::REG_DELTA_SHIFT) bucket_shift = value[4:0];
      else node_limit = value[10:0];
   endtask

   // One graph: k loaded nodes, node_count setting, bucket shift. Runs start only
   // from loaded nodes, and edges reach only loaded nodes or nodes outside the
   // active count, so no unwritten store entry is ever walked.
   task automatic graph_phase(int k, int ncfg, int shift, bit at_top, int runs);
      int deg[0:NODES_MAX];
      int off[0:NODES_MAX];
      int total;
      int base;
      int last_slot;
      int n_eff;
      int val;
      wait_idle();
      csr_write(dss_pkg::REG_DELTA_SHIFT, shift);
      csr_write(dss_pkg::REG_NODE_COUNT, ncfg);
      n_eff = (ncfg > NODES_MAX) ? NODES_MAX : ncfg;
      total = 0;
      for (int u = 0; u < k; u++) begin
         deg[u] = $urandom_range(0, 4);
         total += deg[u];
      end
      base = at_top ? EDGES_MAX - total : $urandom_range(0, EDGES_MAX - 8 - total);
      off[0] = base;
      for (int u = 0; u < k; u++) off[u+1] = off[u] + deg[u];
      last_slot = (off[k] + 4 > EDGES_MAX) ? EDGES_MAX : off[k] + 4;
      for (int s = base; s < last_slot; s++)
         push_req(dss_pkg::OP_WRITE_EDGE, $urandom_range(0, 2047), $urandom_range(0, 8191), s,
                  (n_eff < NODES_MAX && $urandom_range(0, 5) == 0)
                     ? $urandom_range(n_eff, 1023) : $urandom_range(0, k - 1),
                  pick_weight(shift));
      for (int u = 0; u <= k; u++) begin
         val = off[u];
         // Occasionally start past the next offset: an empty edge range.
         if (u > 0 && u < k && $urandom_range(0, 7) == 0) begin
            val = off[u+1] + $urandom_range(1, 3);
            if (val > EDGES_MAX) val = EDGES_MAX;
         end
         push_noop(dss_pkg::OP_WRITE_OFFSET, u, val);
      end
      for (int r = 0; r < runs; r++) begin
         push_noop(dss_pkg::OP_RUN, $urandom_range(0, k - 1), $urandom_range(0, 8191));
         for (int u = 0; u < k; u++) push_noop(dss_pkg::OP_READ, u, $urandom_range(0, 8191));
         push_noop(dss_pkg::OP_READ, $urandom_range(0, 2047), $urandom_range(0, 8191));
         push_noop(dss_pkg::OP_READ, $urandom_range(0, n_eff - 1), $urandom_range(0, 8191));
         // Rejected or harmless items between runs.
         case ($urandom_range(0, 3))
            0: push_noop(dss_pkg::OP_WRITE_OFFSET, $urandom_range(1025, 2047),
                         $urandom_range(0, 4096));
            1: push_noop(dss_pkg::OP_WRITE_OFFSET, $urandom_range(0, 1024),
                         $urandom_range(4097, 8191));
            2: push_noop(dss_pkg::OP_RUN, $urandom_range(n_eff, 2047), $urandom_range(0, 8191));
            default: push_noop(dss_pkg::OP_WRITE_OFFSET, $urandom_range(k + 1, 1024),
                               $urandom_range(0, 4096));
         endcase
      end
   endtask

   initial begin
      int k;
      int ncfg;
      int shift;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.op = dss_pkg::OP_READ;
      req_bus.node = '0;
      req_bus.first_edge = '0;
      req_bus.edge_index = '0;
      req_bus.edge_dest = '0;
      req_bus.edge_weight = '0;
      rsp_bus.ready = 1'b0;
      cycles = 0;
      mismatches = 0;
      planned = 0;
      quiet = 1'b0;
      bucket_shift = dss_pkg::DELTA_SHIFT_RESET;
      node_limit = dss_pkg::NODE_COUNT_RESET;
      for (int v = 0; v < NODES_MAX; v++) dist_of[v] = dss_pkg::UNREACHED;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: reads before any run, range errors, top offset entry.
      push_noop(dss_pkg::OP_READ, 0, 0);
      push_noop(dss_pkg::OP_READ, 1023, 8191);
      push_noop(dss_pkg::OP_READ, 1024, 0);
      push_noop(dss_pkg::OP_READ, 2047, 0);
      push_noop(dss_pkg::OP_WRITE_OFFSET, 1025, 0);
      push_noop(dss_pkg::OP_WRITE_OFFSET, 2047, 4096);
      push_noop(dss_pkg::OP_WRITE_OFFSET, 1024, 4096);
      push_noop(dss_pkg::OP_WRITE_OFFSET, 3, 4097);
      push_noop(dss_pkg::OP_WRITE_OFFSET, 0, 8191);
      push_noop(dss_pkg::OP_RUN, 1024, 0);
      push_noop(dss_pkg::OP_RUN, 2047, 0);

      graph_phase(3, 3, 0, 1'b0, 2);
      graph_phase(1, 1, 31, 1'b0, 1);
      graph_phase(16, 1024, 31, 1'b0, 1);
      graph_phase(12, 2047, 31, 1'b1, 1);
      while (planned < ITEM_GOAL - 60) begin
         k = $urandom_range(2, 20);
         ncfg = k + $urandom_range(0, 10);
         case ($urandom_range(0, 3))
            0: shift = 0;
            1: shift = 31;
            2: shift = $urandom_range(0, 31);
            default: shift = $urandom_range(2, 6);
         endcase
         graph_phase(k, ncfg, shift, $urandom_range(0, 9) == 0, 2);
      end
      wait_idle();
      quiet = 1'b1;
      graph_phase(10, 14, 4, 1'b0, 2);
      wait_idle();
      repeat (20) @(posedge clock);

      if (mismatches == 0) begin
         $display("PASS delta_stepping_sssp");
      end else begin
         $display("FAIL delta_stepping_sssp");
      end
      $finish;
   end

endmodule
`default_nettype wire

[files.f]
sv/dss_pkg.sv
sv/dss_stream_if.sv
sv/dss_graph_store.sv
sv/dss_node_store.sv
sv/dss_engine.sv
sv/delta_stepping_sssp.sv
tb/testbench.sv
